// ----- sv/sps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and datapath operation codes of the segmented prime sieve.
// Used by every module of the block except sps_ram; no dependencies.
package sps_pkg;

  localparam int VAL_W          = 17;
  localparam int LIM_W          = 16;
  localparam int IDX_W          = 13;
  localparam int MAX_LIMIT      = 65535;
  localparam int SEGMENT_SPAN   = 1000;
  localparam int SEGMENT_ODDS   = 500;
  localparam int TABLE_DEPTH    = 8192;
  localparam int NFLAGS         = (SEGMENT_ODDS < SEGMENT_SPAN / 2) ? SEGMENT_ODDS
                                                                    : SEGMENT_SPAN / 2;
  localparam int FLAG_AW        = $clog2(NFLAGS);
  localparam int J_W            = VAL_W + 1;
  localparam int DIV_CW         = $clog2(VAL_W + 1);

  localparam logic [VAL_W-1:0] MAX_LIM_V  = VAL_W'(MAX_LIMIT);
  localparam logic [VAL_W-1:0] SPAN_V     = VAL_W'(SEGMENT_SPAN);
  localparam logic [VAL_W-1:0] SEED_PRIME = VAL_W'(2);

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEG_BEGIN,
    OP_INIT,
    OP_T_START,
    OP_T_READ,
    OP_P_LOAD,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_MUL,
    OP_J_START,
    OP_CROSS,
    OP_T_NEXT,
    OP_SCAN_START,
    OP_SCAN_READ,
    OP_SCAN_NEXT,
    OP_APPEND,
    OP_SEG_END,
    OP_ANS_READ,
    OP_RESPOND
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic need_ext;
    logic init_last;
    logic t_in;
    logic sq_ge_end;
    logic div_last;
    logic j_in;
    logic flag_set;
    logic full;
    logic scan_last;
  } status_t;

endpackage

// ----- sv/sps_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sps_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, read one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/sps_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the segmented prime sieve: prime table, flag RAM, divider, multipliers.
// Depends on sps_pkg and sps_ram; driven one operation per cycle by sps_ctrl.
module sps_dp #(
  parameter int TableDepth = sps_pkg::TABLE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sps_pkg::LIM_W-1:0]   limit_i,
  input  logic [sps_pkg::IDX_W-1:0]   index_i,
  input  sps_pkg::cmd_t               cmd_i,
  output sps_pkg::status_t            status_o,
  output logic [sps_pkg::VAL_W-1:0]   prime_o,
  output logic                        found_o,
  output logic                        valid_o
);
  import sps_pkg::*;

  localparam int AddrW = $clog2(TableDepth);
  localparam int CntW  = $clog2(TableDepth + 1);
  localparam int CmpW  = (CntW > IDX_W) ? CntW : IDX_W;

  dp_op_e op;

  logic [VAL_W-1:0]   lim_q, base_q, end_q, last_q, p_q, rem_q, quo_q, prime_q;
  logic [IDX_W-1:0]   idx_q;
  logic [CntW-1:0]    count_q, t_q;
  logic [FLAG_AW-1:0] i_q;
  logic [2*VAL_W-1:0] sq_q;
  logic [DIV_CW-1:0]  dcnt_q;
  logic [J_W-1:0]     m_q, j_q;
  logic               found_q, valid_q;

  logic [VAL_W-1:0]       lim_sat, p_new, tbl_wdata, tbl_rdata;
  logic [VAL_W:0]         rem_sh;
  logic                   div_ge;
  logic [J_W-1:0]         l_odd;
  logic [VAL_W+J_W-1:0]   prod;
  logic                   tbl_we, flag_we, flag_wdata, flag_rdata, hit;
  logic [AddrW-1:0]       tbl_waddr, tbl_raddr;
  logic [FLAG_AW-1:0]     flag_waddr;
  logic [CmpW-1:0]        idx_ext;

  assign op = cmd_i.op;

  // Saturate the limit and form the next survivor value
  assign lim_sat = (VAL_W'(limit_i) > MAX_LIM_V) ? MAX_LIM_V : VAL_W'(limit_i);
  assign p_new   = base_q + VAL_W'({i_q, 1'b1});
  assign idx_ext = CmpW'(idx_q);
  assign hit     = idx_ext < CmpW'(count_q);

  // One restoring divider step: base / p
  assign rem_sh = {rem_q, quo_q[VAL_W-1]};
  assign div_ge = rem_sh >= {1'b0, p_q};

  // Smallest odd multiplier above base / p
  assign l_odd = J_W'(quo_q) + (quo_q[0] ? J_W'(2) : J_W'(1));
  assign prod  = p_q * l_odd;

  // Prime table ports
  assign tbl_we    = ((op == OP_LOAD) && (count_q == '0)) || (op == OP_APPEND);
  assign tbl_waddr = (op == OP_APPEND) ? count_q[AddrW-1:0] : '0;
  assign tbl_wdata = (op == OP_APPEND) ? p_new : SEED_PRIME;
  assign tbl_raddr = (op == OP_ANS_READ) ? idx_ext[AddrW-1:0] : t_q[AddrW-1:0];

  sps_ram #(.Width(VAL_W), .Depth(TableDepth)) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Flag RAM ports
  assign flag_we    = (op == OP_INIT) || (op == OP_CROSS);
  assign flag_waddr = (op == OP_INIT) ? i_q : j_q[FLAG_AW-1:0];
  assign flag_wdata = (op == OP_INIT) && !((base_q == '0) && (i_q == '0));

  sps_ram #(.Width(1), .Depth(NFLAGS)) u_flags (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .raddr_i (i_q),
    .rdata_o (flag_rdata)
  );

  // Control registers: table fill, segment base, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      base_q  <= '0;
      last_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= (op == OP_RESPOND);
      case (op)
        OP_LOAD: begin
          if (count_q == '0) begin
            count_q <= CntW'(1);
            base_q  <= '0;
            last_q  <= SEED_PRIME;
          end
        end
        OP_APPEND: begin
          count_q <= count_q + CntW'(1);
          last_q  <= p_new;
        end
        OP_SEG_END: base_q <= base_q + SPAN_V;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (op)
      OP_LOAD: begin
        lim_q <= lim_sat;
        idx_q <= index_i;
      end
      OP_SEG_BEGIN: begin
        i_q   <= '0;
        end_q <= base_q + SPAN_V;
      end
      OP_INIT, OP_SCAN_NEXT: i_q <= i_q + FLAG_AW'(1);
      OP_SCAN_START: i_q <= '0;
      OP_T_START: t_q <= CntW'(1);
      OP_T_NEXT: t_q <= t_q + CntW'(1);
      OP_P_LOAD: begin
        p_q  <= tbl_rdata;
        sq_q <= tbl_rdata * tbl_rdata;
      end
      OP_DIV_START: begin
        rem_q  <= '0;
        quo_q  <= base_q;
        dcnt_q <= DIV_CW'(VAL_W);
      end
      OP_DIV_STEP: begin
        rem_q  <= div_ge ? VAL_W'(rem_sh - {1'b0, p_q}) : VAL_W'(rem_sh);
        quo_q  <= {quo_q[VAL_W-2:0], div_ge};
        dcnt_q <= dcnt_q - DIV_CW'(1);
      end
      OP_MUL: m_q <= prod[J_W-1:0];
      OP_J_START: j_q <= (m_q - J_W'(base_q) - J_W'(1)) >> 1;
      OP_CROSS: j_q <= j_q + J_W'(p_q);
      OP_APPEND: begin
        p_q <= p_new;
        j_q <= J_W'(i_q) + J_W'(p_new);
      end
      OP_RESPOND: begin
        prime_q <= hit ? tbl_rdata : '0;
        found_q <= hit && (tbl_rdata <= lim_q);
      end
      default: ;
    endcase
  end

  // Status toward the controller
  assign status_o.need_ext  = (last_q <= lim_q) && (count_q < CntW'(TableDepth));
  assign status_o.init_last = i_q == FLAG_AW'(NFLAGS - 1);
  assign status_o.scan_last = i_q == FLAG_AW'(NFLAGS - 1);
  assign status_o.t_in      = t_q < count_q;
  assign status_o.sq_ge_end = sq_q >= (2*VAL_W)'(end_q);
  assign status_o.div_last  = dcnt_q == DIV_CW'(1);
  assign status_o.j_in      = j_q < J_W'(NFLAGS);
  assign status_o.flag_set  = flag_rdata;
  assign status_o.full      = count_q >= CntW'(TableDepth);

  assign prime_o = prime_q;
  assign found_o = found_q;
  assign valid_o = valid_q;

endmodule

// ----- sv/sps_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the segmented prime sieve: issues one datapath operation per cycle.
// Depends on sps_pkg.
module sps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sps_pkg::status_t  status_i,
  output sps_pkg::cmd_t     cmd_o,
  output logic              busy_o
);
  import sps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_INIT, S_TSTART, S_TRD, S_PLD, S_PCHK, S_DIV,
    S_MUL, S_JST, S_XOLD, S_SRD, S_STEST, S_XNEW, S_RESP
  } state_e;

  state_e state_q, state_d;
  dp_op_e op;

  // Pick the operation and the next state
  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op      = OP_LOAD;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.need_ext) begin
          op      = OP_SEG_BEGIN;
          state_d = S_INIT;
        end else begin
          op      = OP_ANS_READ;
          state_d = S_RESP;
        end
      end
      S_INIT: begin
        op = OP_INIT;
        if (status_i.init_last) state_d = S_TSTART;
      end
      S_TSTART: begin
        op      = OP_T_START;
        state_d = S_TRD;
      end
      S_TRD: begin
        if (status_i.t_in) begin
          op      = OP_T_READ;
          state_d = S_PLD;
        end else begin
          op      = OP_SCAN_START;
          state_d = S_SRD;
        end
      end
      S_PLD: begin
        op      = OP_P_LOAD;
        state_d = S_PCHK;
      end
      S_PCHK: begin
        if (status_i.sq_ge_end) begin
          op      = OP_SCAN_START;
          state_d = S_SRD;
        end else begin
          op      = OP_DIV_START;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        op = OP_DIV_STEP;
        if (status_i.div_last) state_d = S_MUL;
      end
      S_MUL: begin
        op      = OP_MUL;
        state_d = S_JST;
      end
      S_JST: begin
        op      = OP_J_START;
        state_d = S_XOLD;
      end
      S_XOLD: begin
        if (status_i.j_in) begin
          op = OP_CROSS;
        end else begin
          op      = OP_T_NEXT;
          state_d = S_TRD;
        end
      end
      S_SRD: begin
        op      = OP_SCAN_READ;
        state_d = S_STEST;
      end
      S_STEST: begin
        if (status_i.flag_set && status_i.full) begin
          op      = OP_SEG_END;
          state_d = S_CHECK;
        end else if (status_i.flag_set) begin
          op      = OP_APPEND;
          state_d = S_XNEW;
        end else if (status_i.scan_last) begin
          op      = OP_SEG_END;
          state_d = S_CHECK;
        end else begin
          op      = OP_SCAN_NEXT;
          state_d = S_SRD;
        end
      end
      S_XNEW: begin
        if (status_i.j_in) begin
          op = OP_CROSS;
        end else if (status_i.scan_last) begin
          op      = OP_SEG_END;
          state_d = S_CHECK;
        end else begin
          op      = OP_SCAN_NEXT;
          state_d = S_SRD;
        end
      end
      S_RESP: begin
        op      = OP_RESPOND;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.op = op;
  assign busy_o   = state_q != S_IDLE;

endmodule

// ----- sv/segmented_prime_sieve_unit.sv -----
`timescale 1ns / 1ps
// Segmented prime sieve: query the n-th prime, extending a stored prime table on demand.
// Depends on sps_pkg, sps_ctrl, sps_dp, sps_ram.
//
// Usage:
//   A query beat (limit_i, index_i) is taken at a rising edge with start high and busy
//   low. Before answering, the block sieves 1000-number segments until its largest
//   stored prime exceeds limit_i or its table is full, appending every new prime to the table.
//   The answer (prime_o, found_o) shows for exactly one cycle with valid_o high.
//   The receiver cannot stall; the answer is simply gone after that cycle.
// Operation:
//   A query already covered by the table goes from the check straight to the table
//   read and the answer. Each segment extension initialises the 500 odd flags, then
//   crosses the flags of every stored odd prime whose square is below the segment end,
//   starting from an offset found with the bit-serial divider, then scans the flags,
//   appending each survivor and crossing its own multiples. One query is in flight
//   at a time; busy stays high until the answer cycle, in which a new query can
//   already be taken.
// Reset:
//   The table is emptied (fill count zero) and the segment base returns to zero;
//   the first query seeds the table with 2. No clearing pass is needed.
module segmented_prime_sieve_unit #(
  parameter int TableDepth = sps_pkg::TABLE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [sps_pkg::LIM_W-1:0] limit_i,
  input  logic [sps_pkg::IDX_W-1:0] index_i,
  output logic                      valid_o,
  output logic [sps_pkg::VAL_W-1:0] prime_o,
  output logic                      found_o
);
  import sps_pkg::*;

  cmd_t    cmd;
  status_t status;

  sps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  sps_dp #(.TableDepth(TableDepth)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .limit_i  (limit_i),
    .index_i  (index_i),
    .cmd_i    (cmd),
    .status_o (status),
    .prime_o  (prime_o),
    .found_o  (found_o),
    .valid_o  (valid_o)
  );

endmodule

// ----- sv/sps_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker of the segmented prime sieve, bound to the top level.
// Depends on sps_pkg for widths.
module sps_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      valid_o,
  input logic [sps_pkg::VAL_W-1:0] prime_o,
  input logic                      found_o
);

  // An answer beat comes only after the query finished
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> !busy)
    else $error("answer while busy");

  // An accepted query makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("query accepted but not busy");

  // Busy ends only with an answer beat
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy) |-> valid_o)
    else $error("busy dropped without answer");

  // Answer beat lasts a single cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |=> !valid_o)
    else $error("answer strobe longer than one cycle");

  // A found answer carries a real prime
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (valid_o && found_o) |-> (prime_o != '0))
    else $error("found with zero prime");

endmodule

bind segmented_prime_sieve_unit sps_checker u_sps_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o),
  .prime_o (prime_o),
  .found_o (found_o)
);

// ----- verif/segmented_prime_sieve_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for segmented_prime_sieve_unit: random and directed prime queries,
// checked against an in-bench segmented sieve. Depends on sps_pkg and the block's RTL.
module segmented_prime_sieve_unit_tb;
  import sps_pkg::*;

  localparam int NUM_RANDOM  = 600;
  localparam int IDLE_LIMIT  = 2000000;

  // Mirror of the block's prime table; predicts each query's answer.
  class prime_scoreboard;
    longint unsigned primes[TABLE_DEPTH];
    int unsigned     stored;
    longint unsigned seg_no;
    bit              odd_ok[SEGMENT_ODDS];
    logic [VAL_W-1:0] want_prime[$];
    logic             want_found[$];
    int unsigned     mismatches;
    int unsigned     answers;
    int unsigned     hits;

    function new();
      stored = 0;
      seg_no = 0;
      mismatches = 0;
      answers = 0;
      hits = 0;
    endfunction

    // Sieve the next segment and append its survivors.
    function void sieve_next();
      longint unsigned base, stop, nfl, i, j, t, p, l, m;
      base = longint'(SEGMENT_SPAN) * seg_no;
      stop = base + SEGMENT_SPAN;
      nfl = NFLAGS;
      for (i = 0; i < nfl; i++) odd_ok[i] = !(seg_no == 0 && i == 0);
      for (t = 1; t < stored; t++) begin
        p = primes[t];
        if (p * p >= stop) break;
        l = base / p + 1;
        if (l[0] == 1'b0) l++;
        m = p * l;
        if (m <= base) continue;
        for (j = (m - base - 1) / 2; j < nfl; j += p) odd_ok[j] = 0;
      end
      for (i = 0; i < nfl; i++) begin
        if (!odd_ok[i]) continue;
        if (stored >= TABLE_DEPTH) return;
        p = base + 2 * i + 1;
        primes[stored++] = p;
        for (j = i + p; j < nfl; j += p) odd_ok[j] = 0;
      end
    endfunction

    // Note an accepted query beat and queue its answer.
    function void note(logic [LIM_W-1:0] lim_in, logic [IDX_W-1:0] idx_in);
      longint unsigned lim, pr;
      bit fnd;
      lim = lim_in;
      if (lim > MAX_LIMIT) lim = MAX_LIMIT;
      if (stored == 0) begin
        primes[0] = 2;
        stored = 1;
        seg_no = 0;
      end
      while (primes[stored-1] <= lim && stored < TABLE_DEPTH) begin
        sieve_next();
        seg_no++;
      end
      pr = 0;
      fnd = 0;
      if (idx_in < stored) begin
        pr = primes[idx_in];
        fnd = (pr <= lim);
      end
      want_prime = {want_prime, pr[VAL_W-1:0]};
      want_found = {want_found, fnd};
    endfunction

    // Compare a result beat with the oldest expectation.
    function void check(logic [VAL_W-1:0] got_prime, logic got_found);
      logic [VAL_W-1:0] ep;
      logic ef;
      if (want_prime.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: prime=%0d found=%0d", got_prime, got_found);
        return;
      end
      ep = want_prime.pop_front();
      ef = want_found.pop_front();
      answers++;
      if (ef) hits++;
      if (got_prime !== ep || got_found !== ef) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: prime exp=%0d got=%0d, found exp=%0d got=%0d",
                   ep, got_prime, ef, got_found);
      end
    endfunction

    function int pending();
      return want_prime.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [LIM_W-1:0] limit_i;
  logic [IDX_W-1:0] index_i;
  logic             valid_o;
  logic [VAL_W-1:0] prime_o;
  logic             found_o;

  prime_scoreboard sb = new();
  int unsigned idle_cycles;

  segmented_prime_sieve_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .limit_i (limit_i),
    .index_i (index_i),
    .valid_o (valid_o),
    .prime_o (prime_o),
    .found_o (found_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Check results and note accepted beats; results first so the queue order holds.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) sb.check(prime_o, found_o);
      if (start && !busy) sb.note(limit_i, index_i);
    end
  end

  // Watchdog on cycles without any accepted beat or answer.
  always @(posedge clk_i) begin
    if (!rst_ni || valid_o || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Drive one query and hold it until accepted; start stays high afterwards.
  task automatic send_query(logic [LIM_W-1:0] lim, logic [IDX_W-1:0] idx);
    start   <= 1'b1;
    limit_i <= lim;
    index_i <= idx;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Random query whose limit creeps upward so extension proceeds step by step.
  task automatic random_query(int unsigned k);
    logic [LIM_W-1:0] lim;
    logic [IDX_W-1:0] idx;
    int unsigned ceiling;
    ceiling = 2000 + k * 150;
    if (ceiling > MAX_LIMIT || $urandom_range(0, 9) == 0) ceiling = MAX_LIMIT;
    lim = LIM_W'($urandom_range(0, ceiling));
    if ($urandom_range(0, 9) < 7)
      idx = IDX_W'($urandom_range(0, sb.stored + 20));
    else
      idx = IDX_W'($urandom());
    send_query(lim, idx);
  endtask

  initial begin
    int unsigned k;
    int unsigned burst;
    rst_ni  = 1'b0;
    start   = 1'b0;
    limit_i = '0;
    index_i = '0;
    idle_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: seed query, small limits, prime above limit, index beyond table.
    send_query(16'd0, 13'd0);
    send_query(16'd0, 13'd1);
    send_query(16'd2, 13'd0);
    send_query(16'd1, 13'd5);
    send_query(16'd999, 13'd167);
    send_query(16'd999, 13'd168);
    pause_sender(3);
    send_query(16'd1000, 13'd168);
    send_query(16'd1009, 13'd168);
    send_query(16'd5000, 13'd8191);
    send_query(16'd5000, 13'd669);
    send_query(16'd3, 13'd100);
    send_query(16'h5555, 13'h0AAA);
    send_query(16'hAAAA, 13'h1555);
    pause_sender(1);

    // Random bursts with gaps; near the midpoint the sender pauses until everything outstanding drains.
    k = 0;
    while (k < NUM_RANDOM) begin
      burst = $urandom_range(1, 12);
      for (int unsigned b = 0; b < burst && k < NUM_RANDOM; b++) begin
        random_query(k);
        k++;
      end
      if (k > NUM_RANDOM / 2 && k <= NUM_RANDOM / 2 + 12) begin
        start <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end else if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, 20));
      end
    end

    // Saturating query and the top of every field.
    send_query(16'hFFFF, 13'h1FFF);
    send_query(16'hFFFF, 13'd6541);
    start <= 1'b0;

    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (20) @(posedge clk_i);

    $display("Answered %0d queries, %0d found within limit; table holds %0d primes.",
             sb.answers, sb.hits, sb.stored);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
